// File: hw/rtl/rcm_pkg.sv
// Package: sizes, state encoding and cell structs for the recent color MRU list.
`timescale 1ns / 1ps
`default_nettype none
package rcm_pkg;

  localparam int MAX_ENTRIES = 24;
  localparam int COLOR_W     = 32;
  localparam int POS_W       = 5;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } rcm_state_t;

  // Contents of one cell, handed to its neighbor on each shift
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               match;
  } cell_data_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic               capture;
    logic               shift;
    logic [COLOR_W-1:0] key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/rcm_if.sv
// Interfaces: input color channel and list result channel.
`timescale 1ns / 1ps
`default_nettype none
interface rcm_in_if
  import rcm_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;
  logic               color_valid;

  modport source (output valid, output color, output color_valid, input ready);
  modport sink   (input valid, input color, input color_valid, output ready);
endinterface

interface rcm_out_if
  import rcm_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] entry_color;
  logic [POS_W-1:0]   entry_position;
  logic               was_present;
  logic               last_entry;

  modport source (output valid, output entry_color, output entry_position,
                  output was_present, output last_entry, input ready);
  modport sink   (input valid, input entry_color, input entry_position,
                  input was_present, input last_entry, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rcm_cell.sv
// One list cell: holds an entry and its match flag, shifts from its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module rcm_cell
  import rcm_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       live,
  input  wire cell_data_t nbr,
  output cell_data_t      data
);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      data.match <= live && (data.color == ctrl.key);
    end else if (ctrl.shift) begin
      data <= nbr;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/recent_color_mru_list.sv
// Recent color MRU list: top level with the cell ring and its sequencer.
//
// Keeps up to MAX_ENTRIES (24) distinct ARGB colors, newest first.
// Input channel color_in carries one color and a color_valid flag; an item
// with color_valid low is taken and dropped. A valid color is compared in
// all cells at once in the transfer cycle, then the ring of cells rotates
// once around, MAX_ENTRIES steps, moving the color to the front and
// streaming the updated list out on list_out, newest entry first, with
// last_entry marking the final one and was_present telling a hit.
// The first result is registered in the output register after the state
// register enters the run state; later results follow one per cycle while
// list_out does not stall.
// color_in is ready only while no item is in progress.
// A stall on list_out holds the ring on a step that emits; a result waits
// in the output register until taken. Steps past the list length emit
// nothing and go on during a stall.
// Reset empties the list and drops any result in flight.
`timescale 1ns / 1ps
`default_nettype none
module recent_color_mru_list
  import rcm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  rcm_in_if.sink     color_in,
  rcm_out_if.source  list_out
);

  rcm_state_t         state, state_next;
  logic [IDX_W-1:0]   step;
  logic [CNT_W-1:0]   count;
  logic [COLOR_W-1:0] carry;
  logic               done;

  logic               out_valid;
  logic [COLOR_W-1:0] out_color;
  logic [POS_W-1:0]   out_pos;
  logic               out_hit;
  logic               out_last;

  cell_ctrl_t         ctrl;
  cell_data_t         cells [MAX_ENTRIES];
  cell_data_t         tail_in;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] live_vec;

  logic               take;
  logic               hit;
  logic [CNT_W-1:0]   n_new;
  logic [CNT_W-1:0]   step_ext;
  logic               emit;
  logic               can_load;
  logic               advance;
  logic               at_last;
  logic               last_step;
  logic [COLOR_W-1:0] wb_color;

  // Cell ring: each cell pulls from the next, the tail takes the write-back
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      assign live_vec[gi]  = (CNT_W'(gi) < count);
      assign match_vec[gi] = cells[gi].match;
      if (gi == MAX_ENTRIES - 1) begin : g_tail
        rcm_cell u_cell (
          .clk  (clk),
          .ctrl (ctrl),
          .live (live_vec[gi]),
          .nbr  (tail_in),
          .data (cells[gi])
        );
      end else begin : g_body
        rcm_cell u_cell (
          .clk  (clk),
          .ctrl (ctrl),
          .live (live_vec[gi]),
          .nbr  (cells[gi+1]),
          .data (cells[gi])
        );
      end
    end
  endgenerate

  assign take     = color_in.valid && color_in.ready;
  assign hit      = |match_vec;
  assign step_ext = CNT_W'(step);
  assign n_new    = hit ? count :
                    ((count < CNT_W'(MAX_ENTRIES)) ? count + CNT_W'(1) : count);
  assign emit     = (step_ext < n_new);
  assign can_load = !out_valid || list_out.ready;
  assign advance  = (state == ST_RUN) && (!emit || can_load);
  assign at_last  = (step_ext + CNT_W'(1) == n_new);
  assign last_step = (step == IDX_W'(MAX_ENTRIES - 1));
  // Until the moved color is placed, each slot takes the previous entry
  assign wb_color = done ? cells[0].color : carry;

  always_comb begin
    tail_in.color = wb_color;
    tail_in.match = cells[0].match;
    ctrl.capture  = take && color_in.color_valid;
    ctrl.shift    = advance;
    ctrl.key      = color_in.color;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && color_in.color_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    color_in.ready = (state == ST_IDLE);
  end

  assign list_out.valid          = out_valid;
  assign list_out.entry_color    = out_color;
  assign list_out.entry_position = out_pos;
  assign list_out.was_present    = out_hit;
  assign list_out.last_entry     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.capture) begin
        step <= '0;
        done <= 1'b0;
      end else if (advance) begin
        step <= step + IDX_W'(1);
        done <= done || cells[0].match || at_last;
        if (last_step) begin
          count <= n_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      carry <= color_in.color;
    end else if (advance) begin
      carry <= cells[0].color;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (list_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_color <= wb_color;
      out_pos   <= POS_W'(step);
      out_hit   <= hit;
      out_last  <= at_last;
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_recent_color_mru_list.sv
// Testbench for the recent color MRU list: directed and random colors, scoreboard check.
`timescale 1ns / 1ps
module tb_recent_color_mru_list;
  import rcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE      = 40;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   pos;
    logic               hit;
    logic               last;
  } list_entry_t;

  class mru_scoreboard;
    logic [COLOR_W-1:0] recent[$];   // newest first
    list_entry_t        pending[$];
    int                 mismatches = 0;

    function void note_input(logic [COLOR_W-1:0] c, logic cv);
      list_entry_t e;
      int          found;
      found = -1;
      if (!cv) return;
      foreach (recent[i]) if (found < 0 && recent[i] === c) found = i;
      if (found >= 0) recent.delete(found);
      else if (recent.size() == MAX_ENTRIES) void'(recent.pop_back());
      recent.push_front(c);
      foreach (recent[i]) begin
        e.color = recent[i];
        e.pos   = POS_W'(i);
        e.hit   = (found >= 0);
        e.last  = (i == recent.size() - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_result(logic [COLOR_W-1:0] c, logic [POS_W-1:0] pos,
                               logic hit, logic last);
      list_entry_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: color %h pos %0d hit %b last %b", c, pos, hit, last);
        return;
      end
      e = pending.pop_front();
      if (e.color !== c || e.pos !== pos || e.hit !== hit || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected color %h pos %0d hit %b last %b, got %h %0d %b %b",
                   e.color, e.pos, e.hit, e.last, c, pos, hit, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rcm_in_if  color_in ();
  rcm_out_if list_out ();

  recent_color_mru_list dut (
    .clk      (clk),
    .rst      (rst),
    .color_in (color_in),
    .list_out (list_out)
  );

  mru_scoreboard      sb = new();
  int                 send_idle_pct = 0;
  int                 stall_pct     = 0;
  logic [COLOR_W-1:0] color_pool[POOL_SIZE];
  bit                 timed_out     = 1'b0;

  initial begin
    color_in.valid       = 1'b0;
    color_in.color       = '0;
    color_in.color_valid = 1'b0;
    list_out.ready       = 1'b0;
  end

  always @(negedge clk) begin
    list_out.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && list_out.valid && list_out.ready)
      sb.check_result(list_out.entry_color, list_out.entry_position,
                      list_out.was_present, list_out.last_entry);
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_color(logic [COLOR_W-1:0] c, logic cv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      color_in.valid <= 1'b0;
      @(negedge clk);
    end
    color_in.valid       <= 1'b1;
    color_in.color       <= c;
    color_in.color_valid <= cv;
    do @(posedge clk); while (!color_in.ready);
    sb.note_input(c, cv);
    @(negedge clk);
  endtask

  // Hold the sender until the whole emitted list has drained.
  task automatic wait_for_drain();
    color_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_color($urandom(), 1'b0);            // invalid on an empty list
    send_color(32'h0000_0000, 1'b1);
    send_color(32'hFFFF_FFFF, 1'b1);
    send_color(32'hFFFF_FFFF, 1'b1);         // hit at the front
    send_color(32'h00FF_FFFF, 1'b1);         // differs only in alpha
    send_color(32'h0000_0000, 1'b1);         // hit further back
    send_color($urandom(), 1'b0);            // invalid on a filled list
    // walking ones fill the list and push out the oldest
    for (int k = 0; k < 22; k++) send_color(COLOR_W'(1) << k, 1'b1);
    send_color(sb.recent[sb.recent.size() - 1], 1'b1);  // hit at the last position
    send_color(32'h8000_0000, 1'b1);         // new color on a full list
  endtask

  task automatic run_random(int count);
    int                 sent;
    int                 pick;
    logic [COLOR_W-1:0] c;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_color($urandom(), 1'b0);
      end else begin
        if (pick < 35 && sb.recent.size() != 0)
          c = sb.recent[$urandom_range(0, sb.recent.size() - 1)];
        else if (pick < 80)
          c = color_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
          c = $urandom();
        send_color(c, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    int idle_cycles;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0)
        color_pool[i] = {8'($urandom_range(0, 255)), color_pool[i-1][23:0]};
      else
        color_pool[i] = $urandom();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    fork
      begin
        send_idle_pct = 0;  stall_pct = 0;
        run_directed();
        wait_for_drain();
        run_random(18);
        wait_for_drain();
        send_idle_pct = 78; stall_pct = 0;
        run_random(18);
        wait_for_drain();
        send_idle_pct = 0;  stall_pct = 78;
        run_random(18);
        wait_for_drain();
        send_idle_pct = 19; stall_pct = 19;
        run_random(18);
        wait_for_drain();
        // let the ring finish its rotation and catch any stray result
        repeat (2 * MAX_ENTRIES + 4) @(posedge clk);
      end
      begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
          @(posedge clk);
          if ((color_in.valid && color_in.ready) || (list_out.valid && list_out.ready))
            idle_cycles = 0;
          else
            idle_cycles++;
        end
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
